[rtl/temp_humidity_compensation_core_defines.svh]
// Assertion macros shared by the compensation core RTL.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef TEMP_HUMIDITY_COMPENSATION_CORE_DEFINES_SVH
`define TEMP_HUMIDITY_COMPENSATION_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define THC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define THC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/thc_pkg.sv]
// Package for the temperature/humidity compensation core.
// Holds field widths, register index codes and arithmetic constants; no dependencies.
`default_nettype none

package thc_pkg;

  // Field widths
  localparam int RAW_T_W   = 20;
  localparam int RAW_H_W   = 16;
  localparam int TEMP_W    = 16;
  localparam int HUM_W     = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Number of register stages from input to result
  localparam int THC_STAGES = 12;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAL_T1    = 3'd0,
    REG_CAL_T2    = 3'd1,
    REG_CAL_T3    = 3'd2,
    REG_CAL_H1_H3 = 3'd3,
    REG_CAL_H2    = 3'd4,
    REG_CAL_H4    = 3'd5,
    REG_CAL_H5    = 3'd6,
    REG_CAL_H6    = 3'd7
  } thc_reg_t;

  // Arithmetic constants of the compensation formulas
  localparam logic [31:0] C_FINE_OFS  = 32'd76800;
  localparam logic [31:0] C_A_ROUND   = 32'd16384;
  localparam logic [31:0] C_C_OFS     = 32'd32768;
  localparam logic [31:0] C_D_OFS     = 32'd2097152;
  localparam logic [31:0] C_E_ROUND   = 32'd8192;
  localparam logic [31:0] C_HUM_CLAMP = 32'd419430400;
  localparam logic [31:0] C_T_ROUND   = 32'd128;
  localparam logic [HUM_W-1:0] C_HUM_MAX = 17'd102400;

endpackage

`default_nettype wire

[rtl/thc_in_if.sv]
// Input channel: one raw temperature and humidity sample per request.
// Depends on thc_pkg for field widths.
`default_nettype none

interface thc_in_if import thc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RAW_T_W-1:0] raw_temperature;
  logic [RAW_H_W-1:0] raw_humidity;

  modport source (output valid, output raw_temperature, output raw_humidity, input ready);
  modport sink   (input valid, input raw_temperature, input raw_humidity, output ready);
endinterface

`default_nettype wire

[rtl/thc_out_if.sv]
// Result channel: compensated temperature and humidity per request.
// Depends on thc_pkg for field widths.
`default_nettype none

interface thc_out_if import thc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_centi;
  logic [HUM_W-1:0]         humidity_q10;

  modport source (output valid, output temperature_centi, output humidity_q10, input ready);
  modport sink   (input valid, input temperature_centi, input humidity_q10, output ready);
endinterface

`default_nettype wire

[rtl/thc_cfg_if.sv]
// Configuration write channel: register index and write data per request.
// Depends on thc_pkg for field widths.
`default_nettype none

interface thc_cfg_if import thc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/temp_humidity_compensation_core.sv]
// Temperature/humidity compensation core: twelve-stage pipeline with per-stage valid bits.
// Throughput one per cycle while the result channel is not stalled.
// Each stage holds at most one request and advances when the stage after it is free,
// so a stalled result leaves earlier stages filling; nothing is dropped or repeated.
// Reset (synchronous, active low) empties the pipeline and clears all trim registers to 0.
// Depends on thc_pkg, thc_in_if, thc_out_if, thc_cfg_if and the defines header.
`default_nettype none
`include "temp_humidity_compensation_core_defines.svh"

module temp_humidity_compensation_core import thc_pkg::*; (
  input  wire   clk,
  input  wire   rst_n,
  thc_in_if.sink    in_ch,
  thc_out_if.source out_ch,
  thc_cfg_if.sink   cfg_ch
);

  // Arithmetic shift right on a 32-bit two's-complement word
  function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] n);
    return $unsigned($signed(x) >>> n);
  endfunction

  // ---------------------------------------------------------------------------
  // Trim registers
  // ---------------------------------------------------------------------------
  logic [15:0]        cal_t1_r;
  logic signed [15:0] cal_t2_r;
  logic signed [15:0] cal_t3_r;
  logic [15:0]        cal_h1_h3_r;
  logic [15:0]        cal_h2_r;
  logic [11:0]        cal_h4_r;
  logic [11:0]        cal_h5_r;
  logic [7:0]         cal_h6_r;

  assign cfg_ch.ready = 1'b1;

  // Write the addressed register on each configuration request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_t1_r    <= '0;
      cal_t2_r    <= '0;
      cal_t3_r    <= '0;
      cal_h1_h3_r <= '0;
      cal_h2_r    <= '0;
      cal_h4_r    <= '0;
      cal_h5_r    <= '0;
      cal_h6_r    <= '0;
    end else if (cfg_ch.valid) begin
      unique case (thc_reg_t'(cfg_ch.index))
        REG_CAL_T1:    cal_t1_r    <= cfg_ch.data;
        REG_CAL_T2:    cal_t2_r    <= $signed(cfg_ch.data);
        REG_CAL_T3:    cal_t3_r    <= $signed(cfg_ch.data);
        REG_CAL_H1_H3: cal_h1_h3_r <= cfg_ch.data;
        REG_CAL_H2:    cal_h2_r    <= cfg_ch.data;
        REG_CAL_H4:    cal_h4_r    <= cfg_ch.data[11:0];
        REG_CAL_H5:    cal_h5_r    <= cfg_ch.data[11:0];
        REG_CAL_H6:    cal_h6_r    <= cfg_ch.data[7:0];
        default:       ;
      endcase
    end
  end

  // Humidity trims widened to 32-bit words for the wrapping arithmetic.
  logic [31:0] h1_w, h2_w, h3_w, h5_w, h6_w;
  assign h1_w = {24'd0, cal_h1_h3_r[7:0]};
  assign h3_w = {24'd0, cal_h1_h3_r[15:8]};
  assign h2_w = {{16{cal_h2_r[15]}}, cal_h2_r};
  assign h5_w = {{20{cal_h5_r[11]}}, cal_h5_r};
  assign h6_w = {{24{cal_h6_r[7]}}, cal_h6_r};

  // ---------------------------------------------------------------------------
  // Pipeline flow control
  // ---------------------------------------------------------------------------
  logic [THC_STAGES-1:0] vld_r;
  logic [THC_STAGES-1:0] vld_nxt;
  logic [THC_STAGES-1:0] en;

  // A stage loads when it is empty or its content moves on in the same cycle.
  always_comb begin
    en[THC_STAGES-1] = !vld_r[THC_STAGES-1] || out_ch.ready;
    for (int k = THC_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < THC_STAGES; k++) begin
      if (en[k]) begin
        vld_nxt[k] = (k == 0) ? in_ch.valid : vld_r[(k == 0) ? 0 : k - 1];
      end else begin
        vld_nxt[k] = vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ch.ready = en[0];

  // ---------------------------------------------------------------------------
  // Stage 0: temperature differences
  // ---------------------------------------------------------------------------
  logic signed [18:0] d1_nxt, d1_r;
  logic signed [16:0] d2_nxt, d2_r;
  logic [RAW_H_W-1:0] hum_r [0:4];

  assign d1_nxt = $signed({2'b00, in_ch.raw_temperature[19:3]})
                - $signed({2'b00, cal_t1_r, 1'b0});
  assign d2_nxt = $signed({1'b0, in_ch.raw_temperature[19:4]}) - $signed({1'b0, cal_t1_r});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d1_r     <= d1_nxt;
      d2_r     <= d2_nxt;
      hum_r[0] <= in_ch.raw_humidity;
    end
    // Humidity sample rides along until stage 5 uses it.
    for (int k = 1; k <= 4; k++) begin
      if (en[k]) begin
        hum_r[k] <= hum_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: linear term product and square of the second difference
  // ---------------------------------------------------------------------------
  logic signed [34:0] ma_nxt, ma_r;
  logic signed [33:0] sq_full;
  logic [31:0]        sq_r;

  assign ma_nxt  = d1_r * cal_t2_r;
  assign sq_full = d2_r * d2_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ma_r <= ma_nxt;
      sq_r <= sq_full[31:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: scale linear term, quadratic term product
  // ---------------------------------------------------------------------------
  logic signed [23:0] va_r;
  logic signed [36:0] vbm_nxt, vbm_r;

  assign vbm_nxt = $signed({1'b0, sq_r[31:12]}) * cal_t3_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      va_r  <= ma_r[34:11];
      vbm_r <= vbm_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: fine temperature and its humidity offset
  // ---------------------------------------------------------------------------
  logic signed [24:0] fine_nxt, fine_r;
  logic [31:0]        hv_nxt, hv_r;

  assign fine_nxt = {va_r[23], va_r} + {{2{vbm_r[36]}}, vbm_r[36:14]};
  assign hv_nxt   = {{7{fine_nxt[24]}}, fine_nxt} - C_FINE_OFS;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      fine_r <= fine_nxt;
      hv_r   <= hv_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: temperature in hundredths with saturation, first humidity products
  // ---------------------------------------------------------------------------
  logic [31:0]        tx, ty;
  logic signed [15:0] temp_nxt;
  logic signed [15:0] tc_r [4:THC_STAGES-1];
  logic [31:0]        p5_nxt, p6_nxt, p3_nxt;
  logic [31:0]        p5_r, p6_r, p3_r;

  assign tx = {{7{fine_r[24]}}, fine_r} * 32'd5 + C_T_ROUND;
  assign ty = asr32(tx, 5'd8);

  always_comb begin
    priority if ($signed(ty) > 32'sd32767) begin
      temp_nxt = 16'sh7FFF;
    end else if ($signed(ty) < -32'sd32768) begin
      temp_nxt = 16'sh8000;
    end else begin
      temp_nxt = $signed(ty[15:0]);
    end
  end

  assign p5_nxt = h5_w * hv_r;
  assign p6_nxt = hv_r * h6_w;
  assign p3_nxt = hv_r * h3_w;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      tc_r[4] <= temp_nxt;
      p5_r    <= p5_nxt;
      p6_r    <= p6_nxt;
      p3_r    <= p3_nxt;
    end
    // Temperature result rides along to the output stage.
    for (int k = 5; k < THC_STAGES; k++) begin
      if (en[k]) begin
        tc_r[k] <= tc_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: humidity terms a, b and c
  // ---------------------------------------------------------------------------
  logic [31:0] a_sum;
  logic [31:0] a_r [5:7];
  logic [31:0] b_r, c_r;

  assign a_sum = {2'b00, hum_r[4], 14'd0} - {cal_h4_r, 20'd0} - p5_r + C_A_ROUND;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      a_r[5] <= asr32(a_sum, 5'd15);
      b_r    <= asr32(p6_r, 5'd10);
      c_r    <= asr32(p3_r, 5'd11) + C_C_OFS;
    end
    for (int k = 6; k <= 7; k++) begin
      if (en[k]) begin
        a_r[k] <= a_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: product b * c
  // ---------------------------------------------------------------------------
  logic [31:0] bc_nxt, bc_r;

  assign bc_nxt = b_r * c_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      bc_r <= bc_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: d times the second humidity trim
  // ---------------------------------------------------------------------------
  logic [31:0] d_w, de_nxt, de_r;

  assign d_w    = asr32(bc_r, 5'd10) + C_D_OFS;
  assign de_nxt = d_w * h2_w;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      de_r <= de_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 8: scaled humidity intermediate a * e
  // ---------------------------------------------------------------------------
  logic [31:0] e_w, ae_nxt;
  logic [31:0] ae_r [8:10];

  assign e_w    = asr32(de_r + C_E_ROUND, 5'd14);
  assign ae_nxt = a_r[7] * e_w;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      ae_r[8] <= ae_nxt;
    end
    for (int k = 9; k <= 10; k++) begin
      if (en[k]) begin
        ae_r[k] <= ae_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 9: square of the scaled intermediate
  // ---------------------------------------------------------------------------
  logic [31:0] f_w, ff_nxt, ff_r;

  assign f_w    = asr32(ae_r[8], 5'd15);
  assign ff_nxt = f_w * f_w;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      ff_r <= ff_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 10: correction term weighted by the first humidity trim
  // ---------------------------------------------------------------------------
  logic [31:0] gh_nxt, gh_r;

  assign gh_nxt = asr32(ff_r, 5'd7) * h1_w;

  always_ff @(posedge clk) begin
    if (en[10]) begin
      gh_r <= gh_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 11: final subtraction, clamp and scaling to Q7.10
  // ---------------------------------------------------------------------------
  logic [31:0]      hv2_w, hcl_w;
  logic [HUM_W-1:0] hum_out_r;

  assign hv2_w = ae_r[10] - asr32(gh_r, 5'd4);

  // Negative values clamp to zero, large ones to the full-scale limit.
  always_comb begin
    priority if (hv2_w[31]) begin
      hcl_w = '0;
    end else if (hv2_w > C_HUM_CLAMP) begin
      hcl_w = C_HUM_CLAMP;
    end else begin
      hcl_w = hv2_w;
    end
  end

  always_ff @(posedge clk) begin
    if (en[11]) begin
      hum_out_r <= hcl_w[28:12];
    end
  end

  // Result channel
  assign out_ch.valid             = vld_r[THC_STAGES-1];
  assign out_ch.temperature_centi = tc_r[THC_STAGES-1];
  assign out_ch.humidity_q10      = hum_out_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `THC_ASSERT_NOW(a_hum_range, vld_r[THC_STAGES-1], hum_out_r <= C_HUM_MAX,
                  "humidity result above full scale")
  `THC_ASSERT_NOW(a_full_stall, ($countones(vld_r) == THC_STAGES) && !out_ch.ready,
                  !in_ch.ready, "input accepted while the full pipeline is stalled")
  `THC_ASSERT_NXT(a_accept_fills, in_ch.valid && in_ch.ready, vld_r[0],
                  "accepted request did not enter the first stage")
  `THC_ASSERT_NXT(a_stall_holds, vld_r[THC_STAGES-1] && !out_ch.ready,
                  vld_r[THC_STAGES-1] && $stable(hum_out_r),
                  "stalled result was lost or changed")

endmodule

`default_nettype wire
